// ===== rtl/aosf_pkg.sv =====
// Package: shared constants, register indexes and defaults of the oversampling scan filter.
package aosf_pkg;

    localparam int SAMPLE_W            = 10;
    localparam int SAMPLES_PER_CHANNEL = 8;
    localparam int DEF_SCAN_CHANNELS   = 4;
    localparam int ROW_W               = 4;
    localparam int MUX_W               = 4;
    localparam int CFG_W               = 10;
    localparam int CFG_IDX_W           = 3;
    localparam int OUT_CH_W            = 3;
    localparam int MUX_REGS            = 5;
    localparam int REF_SLOT            = 4;
    localparam int SUM_W               = SAMPLE_W + 3;
    localparam int FILT_W              = SAMPLE_W + 2;

    localparam logic [SAMPLE_W-1:0] MID_SCALE = SAMPLE_W'(1 << (SAMPLE_W - 1));

    localparam logic [SAMPLE_W-1:0] RST_ADC_MIN  = '0;
    localparam logic [SAMPLE_W-1:0] RST_ADC_MAX  = '1;
    localparam logic [MUX_W-1:0]    RST_MUX_CH0  = 4'd0;
    localparam logic [MUX_W-1:0]    RST_MUX_CH1  = 4'd1;
    localparam logic [MUX_W-1:0]    RST_MUX_CH2  = 4'd4;
    localparam logic [MUX_W-1:0]    RST_MUX_CH3  = 4'd5;
    localparam logic [MUX_W-1:0]    RST_MUX_VREF = 4'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADC_MIN  = 3'd0,
        REG_ADC_MAX  = 3'd1,
        REG_MUX_CH0  = 3'd2,
        REG_MUX_CH1  = 3'd3,
        REG_MUX_CH2  = 3'd4,
        REG_MUX_CH3  = 3'd5,
        REG_MUX_VREF = 3'd6
    } cfg_reg_t;

endpackage

// ===== rtl/aosf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module aosf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/adc_oversample_scan_filter.sv =====
// Top level: round-robin oversampling scan filter with a shared accumulator.
//
//   channel   signals                                  direction  item
//   --------  ---------------------------------------  ---------  --------------------------
//   input     in_valid / in_ready, sample              in         one conversion result
//   output    out_valid / out_ready, next_mux,         out        one result (1 or SCAN_CHANNELS
//             value_valid, out_channel, value, last               per input item)
//   config    cfg_write, cfg_index, cfg_data           in         one register write, no wait
//
// A plain or reference conversion is accepted, then loaded into the output register.
// The conversion that closes a scan starts a pass over every channel: per channel the
// single RAM read port streams nine store rows through one adder, a drain step empties
// the read register, and a calc step filters, clamps and writes row 0 back.
// A result waiting in the output register holds the output load of a plain or reference
// conversion, or the filter step of the next channel; the input is refused meanwhile.
// Reset clears the counters, the output valid bit and the per-entry valid bits of the
// store; an entry never written since reset reads as mid-scale, so no clearing pass runs.
module adc_oversample_scan_filter
    import aosf_pkg::*;
#(
    parameter int SCAN_CHANNELS = DEF_SCAN_CHANNELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // conversion input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  sample,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MUX_W-1:0]     next_mux,
    output logic                 value_valid,
    output logic [OUT_CH_W-1:0]  out_channel,
    output logic [SAMPLE_W-1:0]  value,
    output logic                 last,
    // configuration
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Store layout: row r (0 = previous scan's newest, 1..8 = this scan) of channel c sits
    // at address r * SCAN_CHANNELS + c.
    localparam int DEPTH = (SAMPLES_PER_CHANNEL + 1) * SCAN_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W  = (SCAN_CHANNELS > 1) ? $clog2(SCAN_CHANNELS) : 1;
    localparam int CNT_W = $clog2(SCAN_CHANNELS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ONE   = 5'b00010,
        S_RD    = 5'b00100,
        S_DRAIN = 5'b01000,
        S_CALC  = 5'b10000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] row,
                                              input logic [CH_W-1:0]  ch);
        addr_of = AW'(int'(row) * SCAN_CHANNELS + int'(ch));
    endfunction

    state_t                state_reg;
    logic [CNT_W-1:0]      ci_reg;
    logic [ROW_W-1:0]      si_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic                  pend_reg;
    logic [ROW_W-1:0]      pend_row_reg;
    logic                  rvld_reg;
    logic [DEPTH-1:0]      store_vld_reg;

    logic [SAMPLE_W-1:0]   adc_min_reg;
    logic [SAMPLE_W-1:0]   adc_max_reg;
    logic [MUX_W-1:0]      mux_code_reg [MUX_REGS];

    logic [SUM_W-1:0]      sum_reg;
    logic [SAMPLE_W-1:0]   prev_reg;
    logic [SAMPLE_W-1:0]   newest_reg;

    logic [MUX_W-1:0]      one_mux_reg;
    logic                  one_ref_reg;
    logic [SAMPLE_W-1:0]   one_sample_reg;

    logic                  out_valid_reg;
    logic [MUX_W-1:0]      next_mux_reg;
    logic                  value_valid_reg;
    logic [OUT_CH_W-1:0]   out_channel_reg;
    logic [SAMPLE_W-1:0]   value_reg;
    logic                  last_reg;

    // accept-time counter update
    logic [CNT_W-1:0]      ci_inc;
    logic [CNT_W-1:0]      ci_next;
    logic [ROW_W-1:0]      si_next;
    logic                  scan_end;
    logic                  was_ref;
    logic                  accept;
    logic [2:0]            mux_sel;

    // store access
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SAMPLE_W-1:0]   ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [SAMPLE_W-1:0]   rd_eff;

    // filter datapath
    logic                  out_free;
    logic                  out_load;
    logic                  calc_fire;
    logic                  last_ch;
    logic                  sum_clr;
    logic signed [SAMPLE_W:0]   delta;
    logic signed [FILT_W-1:0]   filt;
    logic signed [FILT_W-1:0]   lo_clamp;
    logic signed [FILT_W-1:0]   hi_clamp;
    logic signed [FILT_W-1:0]   after_lo;
    logic signed [FILT_W-1:0]   after_hi;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign next_mux    = next_mux_reg;
    assign value_valid = value_valid_reg;
    assign out_channel = out_channel_reg;
    assign value       = value_reg;
    assign last        = last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign calc_fire = (state_reg == S_CALC) && out_free;
    assign out_load  = ((state_reg == S_ONE) && out_free) || calc_fire;
    assign last_ch   = (ch_reg == CH_W'(SCAN_CHANNELS - 1));
    assign was_ref   = (si_reg == ROW_W'(SAMPLES_PER_CHANNEL));

    // Advance channel, then slot; a full slot count with the channel wrapped ends the scan,
    // otherwise restart the scan after the reference.
    always_comb
    begin
        ci_inc   = ci_reg + 1'b1;
        ci_next  = ci_inc;
        si_next  = si_reg;
        scan_end = 1'b0;
        if (ci_inc >= CNT_W'(SCAN_CHANNELS))
        begin
            ci_next = '0;
            si_next = si_reg + 1'b1;
        end
        if (si_next >= ROW_W'(SAMPLES_PER_CHANNEL))
        begin
            if (ci_next == '0)
            begin
                scan_end = 1'b1;
            end
            else
            begin
                si_next = '0;
                ci_next = '0;
            end
        end
        mux_sel = {1'b0, 2'(ci_next)};
    end

    // Store write: new non-reference conversion on accept, row 0 takes the newest sample in the filter step.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_of(ROW_W'(si_reg + 1'b1), CH_W'(ci_reg));
        ram_wdata = sample;
        if (accept && (si_reg < ROW_W'(SAMPLES_PER_CHANNEL)))
        begin
            ram_we = 1'b1;
        end
        else if (calc_fire)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_of('0, ch_reg);
            ram_wdata = newest_reg;
        end
    end

    assign ram_raddr = addr_of(rd_row_reg, ch_reg);
    assign rd_eff    = rvld_reg ? ram_rdata : MID_SCALE;

    aosf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Filter: mean of eight, plus a quarter of the step since the previous scan (floored),
    // then the lower clamp followed by the upper clamp.
    always_comb
    begin
        delta    = $signed({1'b0, newest_reg}) - $signed({1'b0, prev_reg});
        filt     = $signed({2'b00, sum_reg[SUM_W-1:3]}) + FILT_W'(delta >>> 2);
        lo_clamp = $signed({2'b00, adc_min_reg});
        hi_clamp = $signed({2'b00, adc_max_reg});
        after_lo = (filt < lo_clamp) ? lo_clamp : filt;
        after_hi = (after_lo > hi_clamp) ? hi_clamp : after_lo;
    end

    assign sum_clr = (accept && scan_end) || (calc_fire && !last_ch);

    // Sequencer, counters, valid bits, configuration and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ci_reg        <= '0;
            si_reg        <= '0;
            ch_reg        <= '0;
            rd_row_reg    <= '0;
            pend_reg      <= 1'b0;
            store_vld_reg <= '0;
            out_valid_reg <= 1'b0;
            adc_min_reg   <= RST_ADC_MIN;
            adc_max_reg   <= RST_ADC_MAX;
            mux_code_reg[0]        <= RST_MUX_CH0;
            mux_code_reg[1]        <= RST_MUX_CH1;
            mux_code_reg[2]        <= RST_MUX_CH2;
            mux_code_reg[3]        <= RST_MUX_CH3;
            mux_code_reg[REF_SLOT] <= RST_MUX_VREF;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ADC_MIN:  adc_min_reg            <= cfg_data[SAMPLE_W-1:0];
                    REG_ADC_MAX:  adc_max_reg            <= cfg_data[SAMPLE_W-1:0];
                    REG_MUX_CH0:  mux_code_reg[0]        <= cfg_data[MUX_W-1:0];
                    REG_MUX_CH1:  mux_code_reg[1]        <= cfg_data[MUX_W-1:0];
                    REG_MUX_CH2:  mux_code_reg[2]        <= cfg_data[MUX_W-1:0];
                    REG_MUX_CH3:  mux_code_reg[3]        <= cfg_data[MUX_W-1:0];
                    REG_MUX_VREF: mux_code_reg[REF_SLOT] <= cfg_data[MUX_W-1:0];
                    default:      ;
                endcase
            end

            if (ram_we)
            begin
                store_vld_reg[ram_waddr] <= 1'b1;
            end

            pend_reg <= (state_reg == S_RD);

            // Load a new result, or drop the one just taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ci_reg <= ci_next;
                        si_reg <= si_next;
                        if (scan_end)
                        begin
                            ch_reg     <= '0;
                            rd_row_reg <= '0;
                            state_reg  <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_ONE;
                        end
                    end
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    if (rd_row_reg == ROW_W'(SAMPLES_PER_CHANNEL))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        rd_row_reg <= rd_row_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (out_free)
                    begin
                        if (last_ch)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg     <= ch_reg + 1'b1;
                            rd_row_reg <= '0;
                            state_reg  <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: read tracking, shared accumulator, held single result, output payload
    always_ff @(posedge clk)
    begin
        rvld_reg     <= store_vld_reg[ram_raddr];
        pend_row_reg <= rd_row_reg;

        if (sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (pend_reg && (pend_row_reg != '0))
        begin
            sum_reg <= sum_reg + SUM_W'(rd_eff);
        end

        if (pend_reg)
        begin
            if (pend_row_reg == '0)
            begin
                prev_reg <= rd_eff;
            end
            if (pend_row_reg == ROW_W'(SAMPLES_PER_CHANNEL))
            begin
                newest_reg <= rd_eff;
            end
        end

        if (accept)
        begin
            one_mux_reg    <= mux_code_reg[mux_sel];
            one_ref_reg    <= was_ref;
            one_sample_reg <= sample;
        end

        if ((state_reg == S_ONE) && out_free)
        begin
            next_mux_reg    <= one_mux_reg;
            value_valid_reg <= one_ref_reg;
            out_channel_reg <= one_ref_reg ? OUT_CH_W'(SCAN_CHANNELS) : '0;
            value_reg       <= one_ref_reg ? one_sample_reg : '0;
            last_reg        <= 1'b1;
        end
        else if (calc_fire)
        begin
            next_mux_reg    <= mux_code_reg[REF_SLOT];
            value_valid_reg <= 1'b1;
            out_channel_reg <= OUT_CH_W'(ch_reg);
            value_reg       <= after_hi[SAMPLE_W-1:0];
            last_reg        <= last_ch;
        end
    end

endmodule
